@@ rtl/core/erl_pkg.sv @@
// Shared types and constants for the circular event log.
`default_nettype none

package erl_pkg;

    // Field widths of the request and result transactions.
    localparam int REQ_W   = 3;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int AGE_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOG   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COUNT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MARK  = 3'd4;

    // Entry contents after reset.
    localparam logic [KIND_W-1:0]         KIND_NONE   = '0;
    localparam logic [TIME_W-1:0]         TIME_RESET  = '0;
    localparam logic signed [VALUE_W-1:0] VALUE_RESET = -32'sd500;

    // Largest run length the count field can report.
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // One stored log entry.
    typedef struct packed {
        logic [TIME_W-1:0]         etime;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic do_log;
        logic do_mark;
        logic scan_step;
        logic age_mod;
        logic read_addr;
        logic read_data;
        logic load_out;
    } erl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic out_free;
    } erl_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/erl_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module erl_ctrl
    import erl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic [REQ_W-1:0] s_req_type,
    output logic                  s_ready,
    output erl_cmd_t              cmd,
    input  wire erl_sts_t         sts
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOG,
        ST_MARK,
        ST_SCAN,
        ST_RMOD,
        ST_RADDR,
        ST_RDATA,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    // Commands decode from the current state, with the accept and output-load strobes also gated by the handshakes.
    always_comb begin
        cmd            = '0;
        cmd.accept     = s_valid && s_ready_reg;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.do_log     = (state_reg == ST_LOG);
        cmd.do_mark    = (state_reg == ST_MARK);
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.age_mod    = (state_reg == ST_RMOD);
        cmd.read_addr  = (state_reg == ST_RADDR);
        cmd.read_data  = (state_reg == ST_RDATA);
        cmd.load_out   = (state_reg == ST_FINISH) && sts.out_free;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    unique case (s_req_type)
                        REQ_LOG:   state_next = ST_LOG;
                        REQ_COUNT: state_next = ST_SCAN;
                        REQ_READ:  state_next = ST_RMOD;
                        REQ_FIND:  state_next = ST_SCAN;
                        REQ_MARK:  state_next = ST_MARK;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LOG:   state_next = ST_FINISH;
            ST_MARK:  state_next = ST_FINISH;
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_RMOD:  state_next = ST_RADDR;
            ST_RADDR: state_next = ST_RDATA;
            ST_RDATA: state_next = ST_FINISH;
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // State and the registered ready output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/erl_dpath.sv @@
// Datapath with the entry and sent-flag memories, scan logic and result registers.
`default_nettype none

module erl_dpath
    import erl_pkg::*;
#(
    parameter int LOG_DEPTH = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [REQ_W-1:0]             s_req_type,
    input  wire logic [TIME_W-1:0]            s_event_time,
    input  wire logic [KIND_W-1:0]            s_event_kind,
    input  wire logic signed [VALUE_W-1:0]    s_event_value,
    input  wire logic [AGE_W-1:0]             s_age,
    input  wire logic [SLOT_W-1:0]            s_mark_slot,
    input  wire erl_cmd_t                     cmd,
    output erl_sts_t                          sts,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_found,
    output logic [SLOT_W-1:0]                 m_slot,
    output logic [COUNT_W-1:0]                m_entry_count,
    output logic [TIME_W-1:0]                 m_out_time,
    output logic [KIND_W-1:0]                 m_out_kind,
    output logic signed [VALUE_W-1:0]         m_out_value
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int MW = AW + AGE_W + 1;
    localparam int XW = AW + SLOT_W;
    localparam int EW = CW + COUNT_W;
    localparam logic [AW-1:0]   LAST_SLOT = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0]   DEPTH_C   = CW'(LOG_DEPTH);
    localparam logic [CW-1:0]   LAST_C    = CW'(LOG_DEPTH - 1);
    localparam logic [AW+1:0]   DEPTH_S   = (AW + 2)'(LOG_DEPTH);
    localparam logic [XW-1:0]   DEPTH_X   = XW'(LOG_DEPTH);

    // Low bits of a slot index as reported in the result.
    function automatic logic [SLOT_W-1:0] low_slot(input logic [AW-1:0] s);
        logic [XW-1:0] ext;
        ext = XW'(s);
        return ext[SLOT_W-1:0];
    endfunction

    // Storage.
    entry_t data_mem [LOG_DEPTH];
    logic   sent_mem [LOG_DEPTH];
    entry_t rd_entry_reg;
    logic   rd_sent_reg;

    // Captured request.
    logic [REQ_W-1:0]          req_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [KIND_W-1:0]         kind_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [AGE_W-1:0]          age_reg;
    logic [SLOT_W-1:0]         mark_reg;

    // Control registers.
    logic [AW-1:0] newest_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] iss_reg;
    logic [CW-1:0] chk_reg;
    logic          pipe_vld_reg;
    logic          m_valid_reg;

    // Working registers.
    logic [AW-1:0] pipe_slot_reg;
    logic [AW-1:0] agem_reg;

    // Result staging and output registers.
    logic                      res_found_reg;
    logic [SLOT_W-1:0]         res_slot_reg;
    logic [COUNT_W-1:0]        res_count_reg;
    logic [TIME_W-1:0]         res_time_reg;
    logic [KIND_W-1:0]         res_kind_reg;
    logic signed [VALUE_W-1:0] res_value_reg;
    logic                      m_found_reg;
    logic [SLOT_W-1:0]         m_slot_reg;
    logic [COUNT_W-1:0]        m_count_reg;
    logic [TIME_W-1:0]         m_time_reg;
    logic [KIND_W-1:0]         m_kind_reg;
    logic signed [VALUE_W-1:0] m_value_reg;

    // Combinational signals.
    logic [AW-1:0]   log_slot;
    logic [AW-1:0]   ptr_before;
    logic [MW-1:0]   rem;
    logic [MW-1:0]   div_step;
    logic [AW-1:0]   agem_next;
    logic [AW+1:0]   rsum;
    logic [AW-1:0]   read_slot;
    logic [AW-1:0]   rd_addr;
    logic [XW-1:0]   mark_ext;
    logic            mark_ok;
    logic            dwr_en;
    logic [AW-1:0]   dwr_addr;
    entry_t          dwr_entry;
    logic            fwr_en;
    logic [AW-1:0]   fwr_addr;
    logic            scan_issue;
    logic            scan_hit;
    logic            scan_full;
    logic [CW-1:0]   scan_count;
    logic [EW-1:0]   count_ext;
    logic [COUNT_W-1:0] count_sat;

    // Slot that a log request writes, and the slot before the scan pointer.
    assign log_slot   = (newest_reg == LAST_SLOT) ? '0 : newest_reg + AW'(1);
    assign ptr_before = (ptr_reg == '0) ? LAST_SLOT : ptr_reg - AW'(1);

    // Age reduced modulo the depth by restoring shift-and-subtract steps.
    always_comb begin
        rem      = MW'(age_reg);
        div_step = '0;
        for (int k = AGE_W - 1; k >= 0; k--) begin
            div_step = MW'(LOG_DEPTH) << k;
            if (rem >= div_step) begin
                rem = rem - div_step;
            end
        end
        agem_next = rem[AW-1:0];
    end

    // Slot that lies the reduced age before the newest one.
    always_comb begin
        rsum = {2'b00, newest_reg} + DEPTH_S - {2'b00, agem_reg};
        if (rsum >= DEPTH_S) begin
            rsum = rsum - DEPTH_S;
        end
        read_slot = rsum[AW-1:0];
    end

    // Mark requests beyond the depth are ignored.
    assign mark_ext = XW'(mark_reg);
    assign mark_ok  = (mark_ext < DEPTH_X);

    // Write ports of both memories.
    always_comb begin
        dwr_en    = cmd.clear_step || cmd.do_log;
        dwr_addr  = cmd.clear_step ? clr_addr_reg : log_slot;
        dwr_entry = cmd.clear_step ? entry_t'{TIME_RESET, KIND_NONE, VALUE_RESET}
                                   : entry_t'{time_reg, kind_reg, value_reg};
        fwr_en    = cmd.clear_step || cmd.do_log || (cmd.do_mark && mark_ok);
        priority if (cmd.clear_step) begin
            fwr_addr = clr_addr_reg;
        end else if (cmd.do_log) begin
            fwr_addr = log_slot;
        end else begin
            fwr_addr = mark_ext[AW-1:0];
        end
    end

    // Read address: the computed read slot or the scan pointer.
    assign rd_addr = cmd.read_addr ? read_slot : ptr_reg;

    // Memories with registered read data.
    always_ff @(posedge aclk) begin
        if (dwr_en) begin
            data_mem[dwr_addr] <= dwr_entry;
        end
        if (fwr_en) begin
            sent_mem[fwr_addr] <= !cmd.do_log;
        end
        rd_entry_reg <= data_mem[rd_addr];
        rd_sent_reg  <= sent_mem[rd_addr];
    end

    // Backward scan: one read issued and one entry checked each cycle.
    assign scan_issue = cmd.scan_step && (iss_reg < DEPTH_C);
    assign scan_hit   = pipe_vld_reg && ((req_reg == REQ_COUNT) ?
                        (rd_entry_reg.kind == KIND_NONE) : !rd_sent_reg);
    assign scan_full  = pipe_vld_reg && (chk_reg == LAST_C);
    assign scan_count = scan_hit ? chk_reg : DEPTH_C;
    assign count_ext  = EW'(scan_count);
    assign count_sat  = (count_ext > EW'(COUNT_SAT)) ? COUNT_SAT : count_ext[COUNT_W-1:0];

    // Status to the controller.
    always_comb begin
        sts            = '0;
        sts.clear_last = (clr_addr_reg == LAST_SLOT);
        sts.scan_done  = cmd.scan_step && (scan_hit || scan_full);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Control registers: pointers, counters and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg   <= '0;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            iss_reg      <= '0;
            chk_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.do_log) begin
                newest_reg <= log_slot;
            end
            if (cmd.accept) begin
                ptr_reg      <= newest_reg;
                iss_reg      <= '0;
                chk_reg      <= '0;
                pipe_vld_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                pipe_vld_reg <= scan_issue;
                if (scan_issue) begin
                    ptr_reg <= ptr_before;
                    iss_reg <= iss_reg + CW'(1);
                end
                if (pipe_vld_reg && !scan_hit) begin
                    chk_reg <= chk_reg + CW'(1);
                end
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result computation.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg       <= s_req_type;
            time_reg      <= s_event_time;
            kind_reg      <= s_event_kind;
            value_reg     <= s_event_value;
            age_reg       <= s_age;
            mark_reg      <= s_mark_slot;
            res_found_reg <= 1'b0;
            res_slot_reg  <= '0;
            res_count_reg <= '0;
            res_time_reg  <= '0;
            res_kind_reg  <= '0;
            res_value_reg <= '0;
        end
        if (cmd.scan_step) begin
            pipe_slot_reg <= ptr_reg;
        end
        if (cmd.do_log) begin
            res_slot_reg <= low_slot(log_slot);
        end
        if (cmd.do_mark) begin
            res_slot_reg <= mark_reg;
        end
        if (sts.scan_done) begin
            if (req_reg == REQ_COUNT) begin
                res_count_reg <= count_sat;
            end else begin
                res_found_reg <= scan_hit;
                res_slot_reg  <= scan_hit ? low_slot(pipe_slot_reg) : '0;
            end
        end
        if (cmd.age_mod) begin
            agem_reg <= agem_next;
        end
        if (cmd.read_addr) begin
            res_slot_reg <= low_slot(read_slot);
        end
        if (cmd.read_data) begin
            res_time_reg  <= rd_entry_reg.etime;
            res_kind_reg  <= rd_entry_reg.kind;
            res_value_reg <= rd_entry_reg.value;
        end
    end

    // Output register loaded from the staged result.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_found_reg <= res_found_reg;
            m_slot_reg  <= res_slot_reg;
            m_count_reg <= res_count_reg;
            m_time_reg  <= res_time_reg;
            m_kind_reg  <= res_kind_reg;
            m_value_reg <= res_value_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_slot        = m_slot_reg;
    assign m_entry_count = m_count_reg;
    assign m_out_time    = m_time_reg;
    assign m_out_kind    = m_kind_reg;
    assign m_out_value   = m_value_reg;

endmodule

`default_nettype wire

@@ rtl/core/event_ring_log_with_sent_flags_core.sv @@
// From acceptance to result, log and mark requests pass through their own state, a read
// through the age-reduction, address and data states, and an unknown code goes straight to
// the result; count and find scan the entry and flag memories backward one slot per cycle
// through their single read port. One transaction is in progress at a time; a new one is
// taken while a result waits. Reset is synchronous and active low; afterwards a clearing pass
// writes every entry empty and sent before the first transaction is accepted.
`default_nettype none

module event_ring_log_with_sent_flags_core
    import erl_pkg::*;
#(
    parameter int LOG_DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [REQ_W-1:0]          s_req_type,
    input  wire logic [TIME_W-1:0]         s_event_time,
    input  wire logic [KIND_W-1:0]         s_event_kind,
    input  wire logic signed [VALUE_W-1:0] s_event_value,
    input  wire logic [AGE_W-1:0]          s_age,
    input  wire logic [SLOT_W-1:0]         s_mark_slot,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_found,
    output logic [SLOT_W-1:0]              m_slot,
    output logic [COUNT_W-1:0]             m_entry_count,
    output logic [TIME_W-1:0]              m_out_time,
    output logic [KIND_W-1:0]              m_out_kind,
    output logic signed [VALUE_W-1:0]      m_out_value
);

    erl_cmd_t cmd;
    erl_sts_t sts;

    // Request sequencing.
    erl_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Storage, scan and result path.
    erl_dpath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_event_time  (s_event_time),
        .s_event_kind  (s_event_kind),
        .s_event_value (s_event_value),
        .s_age         (s_age),
        .s_mark_slot   (s_mark_slot),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_slot        (m_slot),
        .m_entry_count (m_entry_count),
        .m_out_time    (m_out_time),
        .m_out_kind    (m_out_kind),
        .m_out_value   (m_out_value)
    );

    // An accepted transaction keeps the input closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after a transaction was accepted");

    // The clearing pass never overlaps an open input.
    a_no_ready_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_ready)
        else $error("input ready during the clearing pass");

    // A result appears only through a load of the output register.
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_out))
        else $error("result valid without an output load");

    // A load always presents a result in the next cycle.
    a_load_gives_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("output load did not raise result valid");

endmodule

`default_nettype wire

@@ sim/event_ring_log_with_sent_flags_core_tb.sv @@
// Self-checking testbench for the circular event log core with per-slot sent flags.
`default_nettype none

module event_ring_log_with_sent_flags_core_tb
    import erl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_DEPTH      = 16;
    localparam int TOTAL_REQUESTS = 1850;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 2 * LOG_DEPTH + 8;

    // Request codes that the core does not know.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]          code;
        logic [TIME_W-1:0]         etime;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [AGE_W-1:0]          age;
        logic [SLOT_W-1:0]         mslot;
    } request_t;

    typedef struct packed {
        logic                      found;
        logic [SLOT_W-1:0]         slot;
        logic [COUNT_W-1:0]        run_len;
        logic [TIME_W-1:0]         etime;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } result_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [REQ_W-1:0]          s_req_type = '0;
    logic [TIME_W-1:0]         s_event_time = '0;
    logic [KIND_W-1:0]         s_event_kind = '0;
    logic signed [VALUE_W-1:0] s_event_value = '0;
    logic [AGE_W-1:0]          s_age = '0;
    logic [SLOT_W-1:0]         s_mark_slot = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_found;
    logic [SLOT_W-1:0]         m_slot;
    logic [COUNT_W-1:0]        m_entry_count;
    logic [TIME_W-1:0]         m_out_time;
    logic [KIND_W-1:0]         m_out_kind;
    logic signed [VALUE_W-1:0] m_out_value;

    // Shadow copy of the ring, updated as requests are accepted.
    logic [TIME_W-1:0]         ring_time [LOG_DEPTH];
    logic [KIND_W-1:0]         ring_kind [LOG_DEPTH];
    logic signed [VALUE_W-1:0] ring_value[LOG_DEPTH];
    logic                      ring_sent [LOG_DEPTH];
    int unsigned               ring_newest;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      requests_sent  = 0;
    int      ready_hold     = 0;
    int      idle_cycles    = 0;
    bit      pace_gaps      = 1'b1;

    event_ring_log_with_sent_flags_core #(
        .LOG_DEPTH(LOG_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_event_time (s_event_time),
        .s_event_kind (s_event_kind),
        .s_event_value(s_event_value),
        .s_age        (s_age),
        .s_mark_slot  (s_mark_slot),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_slot       (m_slot),
        .m_entry_count(m_entry_count),
        .m_out_time   (m_out_time),
        .m_out_kind   (m_out_kind),
        .m_out_value  (m_out_value)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Put the shadow ring into its post-reset state.
    function automatic void clear_ring();
        for (int i = 0; i < LOG_DEPTH; i++) begin
            ring_time[i]  = TIME_RESET;
            ring_kind[i]  = KIND_NONE;
            ring_value[i] = VALUE_RESET;
            ring_sent[i]  = 1'b1;
        end
        ring_newest = 0;
    endfunction

    // Apply one request to the shadow ring and return the result it produces.
    function automatic result_t apply_log_request(input request_t rq);
        result_t     r;
        int unsigned s;
        int unsigned n;
        r = '0;
        case (rq.code)
            REQ_LOG: begin
                s = (ring_newest + 1) % LOG_DEPTH;
                ring_newest   = s;
                ring_time[s]  = rq.etime;
                ring_kind[s]  = rq.kind;
                ring_value[s] = rq.value;
                ring_sent[s]  = 1'b0;
                r.slot = s[SLOT_W-1:0];
            end
            REQ_COUNT: begin
                s = ring_newest;
                n = 0;
                while (n < LOG_DEPTH && ring_kind[s] != KIND_NONE) begin
                    n++;
                    s = (s + LOG_DEPTH - 1) % LOG_DEPTH;
                end
                r.run_len = (n > COUNT_SAT) ? COUNT_SAT : n[COUNT_W-1:0];
            end
            REQ_READ: begin
                s = (ring_newest + LOG_DEPTH - (rq.age % LOG_DEPTH)) % LOG_DEPTH;
                r.slot  = s[SLOT_W-1:0];
                r.etime = ring_time[s];
                r.kind  = ring_kind[s];
                r.value = ring_value[s];
            end
            REQ_FIND: begin
                // Newest slot first, then older ones, wrapping once around.
                s = ring_newest;
                for (n = 0; n < LOG_DEPTH; n++) begin
                    if (!ring_sent[s]) begin
                        r.found = 1'b1;
                        r.slot  = s[SLOT_W-1:0];
                        break;
                    end
                    s = (s + LOG_DEPTH - 1) % LOG_DEPTH;
                end
            end
            REQ_MARK: begin
                if (rq.mslot < LOG_DEPTH) ring_sent[rq.mslot] = 1'b1;
                r.slot = rq.mslot;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Build a request of the given code with every field randomized.
    function automatic request_t random_request(input logic [REQ_W-1:0] code);
        request_t rq;
        rq.code  = code;
        rq.etime = $urandom;
        rq.kind  = ($urandom_range(0, 7) == 0) ? KIND_NONE : KIND_W'($urandom_range(1, 15));
        rq.value = $urandom;
        rq.age   = AGE_W'($urandom_range(0, 255));
        rq.mslot = SLOT_W'($urandom_range(0, 15));
        return rq;
    endfunction

    // Drive one request transaction; called and returns at a falling edge.
    task automatic send_request(input request_t rq);
        int gap;
        gap = pace_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= rq.code;
        s_event_time  <= rq.etime;
        s_event_kind  <= rq.kind;
        s_event_value <= rq.value;
        s_age         <= rq.age;
        s_mark_slot   <= rq.mslot;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_log_request(rq));
        requests_sent++;
        @(negedge aclk);
    endtask

    // Result side back-pressure: hold ready low while the randomly drawn hold count runs down.
    initial begin
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_ready <= 1'b0;
                ready_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every accepted result transaction with the oldest prediction.
    initial begin
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                ready_hold = pace_gaps ? $urandom_range(0, 6) : 0;
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: slot %0d", m_slot);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, m_found);
                        mismatch_count++;
                    end
                    if (m_slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, m_slot);
                        mismatch_count++;
                    end
                    if (m_entry_count !== want.run_len) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.run_len, m_entry_count);
                        mismatch_count++;
                    end
                    if (m_out_time !== want.etime) begin
                        $error("out_time: expected %0d, actual %0d", want.etime, m_out_time);
                        mismatch_count++;
                    end
                    if (m_out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, m_out_kind);
                        mismatch_count++;
                    end
                    if (m_out_value !== want.value) begin
                        $error("out_value: expected %0d, actual %0d", want.value, m_out_value);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: stop if no transaction moves on either side for too long.
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAIL event_ring_log_with_sent_flags_core");
        $finish;
    end

    // Reads and searches on the freshly reset log.
    task automatic test_reset_contents();
        request_t rq;
        rq = random_request(REQ_READ);
        rq.age = '0;
        send_request(rq);
        rq = random_request(REQ_READ);
        rq.age = 8'd255;
        send_request(rq);
        send_request(random_request(REQ_COUNT));
        send_request(random_request(REQ_FIND));
    endtask

    // Unknown codes must leave the log alone and return all zeros.
    task automatic test_unknown_requests();
        request_t rq;
        for (int c = REQ_UNKNOWN_FIRST; c <= REQ_UNKNOWN_LAST; c++) begin
            rq = random_request(REQ_W'(c));
            rq.etime = '1;
            rq.kind  = '1;
            rq.value = '1;
            rq.age   = '1;
            rq.mslot = '1;
            send_request(rq);
        end
    endtask

    // Field extremes, an empty kind breaking the run, and age wrapping.
    task automatic test_log_extremes();
        request_t rq;
        rq = random_request(REQ_LOG);
        rq.etime = '0;
        rq.kind  = '1;
        rq.value = 32'sh8000_0000;
        send_request(rq);
        rq = random_request(REQ_LOG);
        rq.etime = '1;
        rq.kind  = 4'd1;
        rq.value = 32'sh7fff_ffff;
        send_request(rq);
        send_request(random_request(REQ_COUNT));
        rq = random_request(REQ_LOG);
        rq.kind  = KIND_NONE;
        rq.value = -32'sd1;
        send_request(rq);
        send_request(random_request(REQ_COUNT));
        rq = random_request(REQ_READ);
        rq.age = 8'd255;
        send_request(rq);
        rq = random_request(REQ_READ);
        rq.age = 8'd2;
        send_request(rq);
    endtask

    // Marking the newest unsent slots walks the search back to older ones.
    task automatic test_find_and_mark();
        request_t rq;
        send_request(random_request(REQ_FIND));
        rq = random_request(REQ_MARK);
        rq.mslot = 4'd3;
        send_request(rq);
        send_request(random_request(REQ_FIND));
        rq = random_request(REQ_MARK);
        rq.mslot = '1;
        send_request(rq);
        rq = random_request(REQ_MARK);
        rq.mslot = 4'd2;
        send_request(rq);
        send_request(random_request(REQ_FIND));
    endtask

    // Random traffic in segments, each with its own shape and pacing.
    task automatic test_random_traffic();
        request_t rq;
        int       shape;
        int       len;
        int       pick;
        while (requests_sent < TOTAL_REQUESTS) begin
            pace_gaps = ($urandom_range(0, 3) != 0);
            shape = $urandom_range(0, 9);
            if (shape < 3) begin
                // Fill the ring to around its depth, sometimes past it, with real events, then query it.
                len = $urandom_range(LOG_DEPTH - 2, LOG_DEPTH + 4);
                for (int i = 0; i < len; i++) begin
                    rq = random_request(REQ_LOG);
                    if (rq.kind == KIND_NONE) rq.kind = KIND_W'($urandom_range(1, 15));
                    send_request(rq);
                end
                send_request(random_request(REQ_COUNT));
                send_request(random_request(REQ_FIND));
                send_request(random_request(REQ_READ));
            end else if (shape < 5) begin
                // Mark slots one by one, searching as the unsent set shrinks.
                for (int i = 0; i < LOG_DEPTH; i++) begin
                    rq = random_request(REQ_MARK);
                    rq.mslot = SLOT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : i);
                    send_request(rq);
                    if ($urandom_range(0, 2) == 0) send_request(random_request(REQ_FIND));
                end
                send_request(random_request(REQ_FIND));
            end else begin
                // Mixed requests with a few unknown codes.
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)      rq = random_request(REQ_LOG);
                    else if (pick < 50) rq = random_request(REQ_COUNT);
                    else if (pick < 70) rq = random_request(REQ_READ);
                    else if (pick < 85) rq = random_request(REQ_FIND);
                    else if (pick < 95) rq = random_request(REQ_MARK);
                    else rq = random_request(REQ_W'($urandom_range(REQ_UNKNOWN_FIRST,
                                                                   REQ_UNKNOWN_LAST)));
                    send_request(rq);
                end
            end
        end
    endtask

    // Main sequence: reset, directed tests, random traffic, drain and verdict.
    initial begin
        clear_ring();
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_contents();
        test_unknown_requests();
        test_log_extremes();
        test_find_and_mark();
        test_random_traffic();

        s_valid <= 1'b0;
        pace_gaps = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS event_ring_log_with_sent_flags_core");
        end else begin
            $display("FAIL event_ring_log_with_sent_flags_core");
        end
        $finish;
    end

endmodule

`default_nettype wire
